// ----- sv/mss_pkg.sv -----
// shared constants, register indexes, control structs and saturation helper
// for the mass-spring string synthesizer; no dependencies
`default_nettype none

package mss_pkg;

  localparam int MAX_MASSES_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STIFFNESS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXCITE_NODE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PICKUP_NODE = 3'd4;

  localparam logic [6:0]  MASS_COUNT_RST = 7'd64;
  localparam logic [15:0] STIFFNESS_RST  = 16'd3277;
  localparam logic [14:0] DAMPING_RST    = 15'd0;

  // pass codes shared by controller and datapath
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_MOVE  = 2'd1;
  localparam logic [1:0] PH_FORCE = 2'd2;

  typedef struct packed {
    logic [6:0]  mass_count;
    logic [15:0] spring_stiffness;
    logic [14:0] damping_factor;
    logic [5:0]  excite_node;
    logic [5:0]  pickup_node;
  } cfg_t;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       issue;
    logic [1:0] phase;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/mss_in_if.sv -----
// input sample channel: valid/ready handshake with the excitation sample
// depends on mss_pkg
`default_nettype none

interface mss_in_if
  import mss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ----- sv/mss_out_if.sv -----
// output sample channel: valid/ready handshake with the pickup sample
// depends on mss_pkg
`default_nettype none

interface mss_out_if
  import mss_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- sv/mss_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ----- sv/mss_cfg.sv -----
// configuration register file, written through a plain index/data port
// depends on mss_pkg
`default_nettype none

module mss_cfg
  import mss_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass_count       <= MASS_COUNT_RST;
      cfg.spring_stiffness <= STIFFNESS_RST;
      cfg.damping_factor   <= DAMPING_RST;
      cfg.excite_node      <= '0;
      cfg.pickup_node      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MASS_COUNT:  cfg.mass_count       <= cfg_data[6:0];
        REG_STIFFNESS:   cfg.spring_stiffness <= cfg_data;
        REG_DAMPING:     cfg.damping_factor   <= cfg_data[14:0];
        REG_EXCITE_NODE: cfg.excite_node      <= cfg_data[5:0];
        REG_PICKUP_NODE: cfg.pickup_node      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end
endmodule

`default_nettype wire

// ----- sv/mss_ctrl.sv -----
// sequencer: clearing pass, position pass, force/velocity pass, result hand-off
// depends on mss_pkg
`default_nettype none

module mss_ctrl
  import mss_pkg::*;
#(
  parameter int MAX_MASSES = MAX_MASSES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [6:0]                           mass_count,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire status_t                              status,
  output cmd_t                                      cmd,
  output logic      [$clog2(MAX_MASSES + 1)-1:0]    cnt,
  output logic      [$clog2(MAX_MASSES + 1)-1:0]    n
);
  localparam int CNT_BITS = $clog2(MAX_MASSES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_WAIT1 = 3'd3;
  localparam logic [2:0] S_FORCE = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state, state_next;
  logic [CNT_BITS-1:0] cnt_next;

  always_comb begin
    if (mass_count == 7'd0) begin
      n = CNT_BITS'(1);
    end else if (32'(mass_count) > MAX_MASSES) begin
      n = CNT_BITS'(MAX_MASSES);
    end else begin
      n = CNT_BITS'(mass_count);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.clear    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.phase    = PH_NONE;
    cmd.load_out = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_BITS'(MAX_MASSES - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.issue = 1'b1;
        cmd.phase = PH_MOVE;
        cnt_next  = cnt + 1'b1;
        if (cnt == n - 1'b1) begin
          state_next = S_WAIT1;
        end
      end
      S_WAIT1: begin
        cmd.phase = PH_MOVE;
        if (!status.busy) begin
          cnt_next   = '0;
          state_next = S_FORCE;
        end
      end
      // one extra slot so the last mass sees its right neighbor window close
      S_FORCE: begin
        cmd.issue = 1'b1;
        cmd.phase = PH_FORCE;
        cnt_next  = cnt + 1'b1;
        if (cnt == n) begin
          state_next = S_WAIT2;
        end
      end
      S_WAIT2: begin
        cmd.phase = PH_FORCE;
        if (!status.busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end
endmodule

`default_nettype wire

// ----- sv/mss_dp.sv -----
// datapath: state rams, high-pass, position update, spring force and
// damped velocity pipeline, output register; depends on mss_pkg and mss_ram
`default_nettype none

module mss_dp
  import mss_pkg::*;
#(
  parameter int MAX_MASSES  = MAX_MASSES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cfg_t                                  cfg,
  input  wire cmd_t                                  cmd,
  input  wire logic [$clog2(MAX_MASSES + 1)-1:0]     cnt,
  input  wire logic [$clog2(MAX_MASSES + 1)-1:0]     n,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
  output status_t                                    status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]              sample_out
);
  localparam int CNT_BITS  = $clog2(MAX_MASSES + 1);
  localparam int ADDR_BITS = (MAX_MASSES > 1) ? $clog2(MAX_MASSES) : 1;

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

  // ram ports
  logic                 pos_we, va_we;
  logic [ADDR_BITS-1:0] pos_waddr, va_waddr, pos_raddr, va_raddr;
  logic [31:0]          pos_wdata, vel_wdata, acc_wdata;
  logic [31:0]          pos_q, vel_q, acc_q;
  logic [CNT_BITS-1:0]  cnt_m1;

  // high-pass
  logic signed [SAMPLE_BITS:0]   hp;
  logic signed [SAMPLE_BITS-1:0] prev_input;

  // clamped pickup index and excite range flag
  logic [31:0] pick;
  logic        excite_in_range;

  // stage 1
  logic                v1_move, v1_force;
  logic [CNT_BITS-1:0] i1;
  logic signed [33:0]  x1;
  logic signed [31:0]  xs1, xe1, move_pos;
  logic signed [31:0]  w1, w2;
  logic signed [34:0]  lap1;
  logic [CNT_BITS-1:0] im1;

  // force pipeline
  logic                 v2, v3, v4, v5, v6;
  logic [ADDR_BITS-1:0] i2, i3, i4, i5, i6;
  logic signed [34:0]   lap2;
  logic signed [31:0]   vel2, acc2, vel3, acc3, vel4, acc4;
  logic signed [51:0]   prod3;
  logic signed [16:0]   kk;
  logic signed [52:0]   neg3;
  logic signed [31:0]   a4, a5, a6, a3n;
  logic signed [32:0]   asum4;
  logic signed [33:0]   vsum4;
  logic signed [31:0]   vs4n, vs5, vs6;
  logic signed [16:0]   dd;
  logic signed [48:0]   dprod6;
  logic signed [33:0]   vf6;

  logic signed [31:0] pick_val;

  assign cnt_m1    = cnt - 1'b1;
  assign pos_raddr = cnt[ADDR_BITS-1:0];
  assign va_raddr  = (cmd.phase == PH_FORCE) ? cnt_m1[ADDR_BITS-1:0] : cnt[ADDR_BITS-1:0];

  assign excite_in_range = 32'(cfg.excite_node) < 32'(n);
  assign pick = (32'(cfg.pickup_node) > 32'(n) - 32'd1) ? 32'(n) - 32'd1
                                                          : 32'(cfg.pickup_node);

  mss_ram #(.WIDTH(32), .DEPTH(MAX_MASSES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_q)
  );
  mss_ram #(.WIDTH(32), .DEPTH(MAX_MASSES)) u_vel_ram (
    .clk(clk), .we(va_we), .waddr(va_waddr), .wdata(vel_wdata),
    .raddr(va_raddr), .rdata(vel_q)
  );
  mss_ram #(.WIDTH(32), .DEPTH(MAX_MASSES)) u_acc_ram (
    .clk(clk), .we(va_we), .waddr(va_waddr), .wdata(acc_wdata),
    .raddr(va_raddr), .rdata(acc_q)
  );

  // position pass: x += v + a/2, plus the high-passed sample at the excite mass
  always_comb begin
    x1       = 34'($signed(pos_q)) + 34'($signed(vel_q)) + 34'($signed(acc_q) >>> 1);
    xs1      = sat32(64'(x1));
    xe1      = sat32(64'(xs1) + 64'(hp));
    move_pos = (32'(cfg.excite_node) == 32'(i1)) ? xe1 : xs1;
  end

  // laplacian for mass i1-1 with free ends, from the three-position window
  assign im1 = i1 - 1'b1;
  always_comb begin
    if (n == CNT_BITS'(1)) begin
      lap1 = 35'(w1);
    end else if (im1 == '0) begin
      lap1 = 35'(w1) - 35'($signed(pos_q));
    end else if (im1 == n - 1'b1) begin
      lap1 = 35'(w1) - 35'(w2);
    end else begin
      lap1 = (35'(w1) <<< 1) - 35'(w2) - 35'($signed(pos_q));
    end
  end

  assign kk    = $signed({1'b0, cfg.spring_stiffness});
  assign neg3  = -53'(prod3);
  assign a3n   = sat32(64'(neg3 >>> 16));
  assign asum4 = 33'(acc4) + 33'(a4);
  assign vsum4 = 34'(vel4) + 34'(asum4 >>> 1);
  assign vs4n  = sat32(64'(vsum4));
  assign dd    = $signed({1'b0, cfg.damping_factor, 1'b0});
  assign vf6   = 34'(vs6) - 34'(dprod6 >>> 16);

  // ram write muxing, clearing pass has priority
  always_comb begin
    if (cmd.clear) begin
      pos_we    = 1'b1;
      pos_waddr = cnt[ADDR_BITS-1:0];
      pos_wdata = '0;
      va_we     = 1'b1;
      va_waddr  = cnt[ADDR_BITS-1:0];
      vel_wdata = '0;
      acc_wdata = '0;
    end else begin
      pos_we    = v1_move;
      pos_waddr = i1[ADDR_BITS-1:0];
      pos_wdata = move_pos;
      va_we     = v6;
      va_waddr  = i6;
      vel_wdata = sat32(64'(vf6));
      acc_wdata = a6;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hp <= (SAMPLE_BITS + 1)'(sample_in) - (SAMPLE_BITS + 1)'(prev_input);
    end
    i1 <= cnt;
    if (v1_force) begin
      w2 <= w1;
      w1 <= $signed(pos_q);
    end
    if (v1_move && (32'(i1) == pick)) begin
      pick_val <= move_pos;
    end
    lap2   <= lap1;
    vel2   <= $signed(vel_q);
    acc2   <= $signed(acc_q);
    i2     <= im1[ADDR_BITS-1:0];
    prod3  <= kk * lap2;
    vel3   <= vel2;
    acc3   <= acc2;
    i3     <= i2;
    a4     <= a3n;
    vel4   <= vel3;
    acc4   <= acc3;
    i4     <= i3;
    vs5    <= vs4n;
    a5     <= a4;
    i5     <= i4;
    dprod6 <= dd * vs5;
    vs6    <= vs5;
    a6     <= a5;
    i6     <= i5;
    if (cmd.load_out) begin
      if (64'(pick_val) > OUT_MAX) begin
        sample_out <= OUT_MAX[SAMPLE_BITS-1:0];
      end else if (64'(pick_val) < OUT_MIN) begin
        sample_out <= OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
        sample_out <= pick_val[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_input <= '0;
      v1_move    <= 1'b0;
      v1_force   <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      v5         <= 1'b0;
      v6         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the previous sample only moves when the excite mass is in use
      if (cmd.accept && excite_in_range) begin
        prev_input <= sample_in;
      end
      v1_move  <= cmd.issue && (cmd.phase == PH_MOVE);
      v1_force <= cmd.issue && (cmd.phase == PH_FORCE);
      v2       <= v1_force && (i1 != '0);
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      v6       <= v5;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.busy     = v1_move | v1_force | v2 | v3 | v4 | v5 | v6;
  assign status.out_full = out_valid & ~out_ready;
endmodule

`default_nettype wire

// ----- sv/mass_spring_string_verlet_synth_top.sv -----
// mass-spring string synthesizer, one velocity-verlet step per input transaction
// each transaction: a ram pass for positions, one pass through the six-stage force
// and damping pipeline, then the result hand-off, which waits while the output
// register holds an untaken result; new input is accepted only after the hand-off
// reset: a clearing pass zeroes all MAX_MASSES words of the state rams, input not ready
// depends on mss_pkg, mss_in_if, mss_out_if, mss_cfg, mss_ctrl, mss_dp
`default_nettype none

module mass_spring_string_verlet_synth_top
  import mss_pkg::*;
#(
  parameter int MAX_MASSES  = MAX_MASSES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  mss_in_if.sink                         excite,
  mss_out_if.source                      pickup
);
  localparam int CNT_BITS = $clog2(MAX_MASSES + 1);

  cfg_t                cfg;
  cmd_t                cmd;
  status_t             status;
  logic [CNT_BITS-1:0] cnt, n;

  mss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mss_ctrl #(.MAX_MASSES(MAX_MASSES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .mass_count (cfg.mass_count),
    .in_valid   (excite.valid),
    .in_ready   (excite.ready),
    .status     (status),
    .cmd        (cmd),
    .cnt        (cnt),
    .n          (n)
  );

  mss_dp #(.MAX_MASSES(MAX_MASSES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .cnt        (cnt),
    .n          (n),
    .sample_in  (excite.sample_in),
    .status     (status),
    .out_valid  (pickup.valid),
    .out_ready  (pickup.ready),
    .sample_out (pickup.sample_out)
  );
endmodule

`default_nettype wire

// ----- test/tb_mass_spring_string_verlet_synth_top.sv -----
// testbench for mass_spring_string_verlet_synth_top: random and directed excitation
// samples checked against a cycle-free velocity-verlet predictor of the string
// depends on mss_pkg, mss_in_if, mss_out_if and the synthesizer top level
`timescale 1ns / 1ps

module tb_mass_spring_string_verlet_synth_top;
  import mss_pkg::*;

  localparam int NUM_MASSES   = MAX_MASSES_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_PRINTS   = 100;

  logic clk;
  logic rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mss_in_if  excite_ch ();
  mss_out_if pickup_ch ();

  mass_spring_string_verlet_synth_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .excite    (excite_ch),
    .pickup    (pickup_ch)
  );

  // predictor copy of the registers and the string state
  logic [6:0]  cfg_masses;
  logic [15:0] cfg_stiff;
  logic [14:0] cfg_damp;
  logic [5:0]  cfg_excite;
  logic [5:0]  cfg_pickup;
  int          mass_pos [NUM_MASSES];
  int          mass_vel [NUM_MASSES];
  int          mass_acc [NUM_MASSES];
  longint      prev_injected;

  logic signed [23:0] sample_queue [$];
  logic signed [23:0] expected_out [$];
  logic signed [23:0] want;
  logic signed [23:0] last_sample;
  logic               in_fire;
  logic               steady;
  int                 in_gap;
  int                 ready_hold;
  int                 fail_count;
  int                 results_seen;
  int                 idle_cycles;

  always #6 clk = ~clk;

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int spring_accel(input longint lap);
    return clamp32((-longint'(cfg_stiff) * lap) >>> 16);
  endfunction

  function automatic void clear_string();
    for (int i = 0; i < NUM_MASSES; i++) begin
      mass_pos[i] = 0;
      mass_vel[i] = 0;
      mass_acc[i] = 0;
    end
    prev_injected = 0;
    cfg_masses = MASS_COUNT_RST;
    cfg_stiff  = STIFFNESS_RST;
    cfg_damp   = DAMPING_RST;
    cfg_excite = '0;
    cfg_pickup = '0;
  endfunction

  // one verlet step of the string; returns the pickup sample
  function automatic logic signed [23:0] verlet_step(input logic signed [23:0] smp_in);
    int     n;
    int     pick;
    int     vs;
    longint smp;
    longint v;
    longint res;
    int     accel_next [NUM_MASSES];
    n = cfg_masses;
    if (n < 1) n = 1;
    if (n > NUM_MASSES) n = NUM_MASSES;
    smp = smp_in;
    for (int i = 0; i < n; i++) begin
      mass_pos[i] = clamp32(longint'(mass_pos[i]) + mass_vel[i] + (longint'(mass_acc[i]) >>> 1));
      if (i == int'(cfg_excite)) begin
        mass_pos[i] = clamp32(longint'(mass_pos[i]) + (smp - prev_injected));
        prev_injected = smp;
      end
    end
    if (n == 1) begin
      accel_next[0] = spring_accel(mass_pos[0]);
    end else begin
      accel_next[0] = spring_accel(longint'(mass_pos[0]) - mass_pos[1]);
      for (int i = 1; i + 1 < n; i++) begin
        accel_next[i] = spring_accel(-longint'(mass_pos[i-1]) + 2 * longint'(mass_pos[i])
                                     - longint'(mass_pos[i+1]));
      end
      accel_next[n-1] = spring_accel(longint'(mass_pos[n-1]) - mass_pos[n-2]);
    end
    for (int i = 0; i < n; i++) begin
      vs = clamp32(longint'(mass_vel[i]) + ((longint'(mass_acc[i]) + accel_next[i]) >>> 1));
      mass_acc[i] = accel_next[i];
      v = longint'(vs) - ((2 * longint'(cfg_damp) * vs) >>> 16);
      mass_vel[i] = clamp32(v);
    end
    pick = cfg_pickup;
    if (pick > n - 1) pick = n - 1;
    res = mass_pos[pick];
    if (res > 64'sd8388607) res = 64'sd8388607;
    if (res < -64'sd8388608) res = -64'sd8388608;
    return res[23:0];
  endfunction

  // mostly short gaps, a few long ones, none in steady phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic signed [23:0] make_sample();
    int                 r;
    logic signed [23:0] s;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      s = 24'($urandom_range(0, 131071));
      s = s - 24'sd65536;
    end else if (r < 60) begin
      s = 24'($urandom());
    end else if (r < 75) begin
      s = '0;
    end else if (r < 85) begin
      s = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
    end else begin
      s = last_sample;
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [23:0] got,
                                 input logic signed [23:0] exp_val);
    if (fail_count < MAX_PRINTS)
      $display("%0t: %s: sample_out got %0d want %0d (result %0d)",
               $realtime, what, got, exp_val, results_seen);
    fail_count++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MASS_COUNT:  cfg_masses = data[6:0];
      REG_STIFFNESS:   cfg_stiff  = data;
      REG_DAMPING:     cfg_damp   = data[14:0];
      REG_EXCITE_NODE: cfg_excite = data[5:0];
      REG_PICKUP_NODE: cfg_pickup = data[5:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic signed [23:0] s);
    sample_queue = {sample_queue, s};
    last_sample = s;
  endtask

  // sender holds off until every pending result has come back
  task automatic drain_all();
    do @(posedge clk);
    while (sample_queue.size() != 0 || excite_ch.valid || expected_out.size() != 0);
  endtask

  task automatic random_setup();
    int          r;
    int          n_eff;
    logic [15:0] val;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 6))
        0: val = 16'd0;
        1: val = 16'd1;
        2: val = 16'd2;
        3: val = 16'd63;
        4: val = 16'd64;
        5: val = 16'd65;
        default: val = 16'd127;
      endcase
    end else if (r < 70) begin
      val = 16'($urandom_range(1, 8));
    end else begin
      val = 16'($urandom_range(0, 127));
    end
    write_reg(REG_MASS_COUNT, val);
    n_eff = (val == 0) ? 1 : (val > NUM_MASSES) ? NUM_MASSES : int'(val);
    r = $urandom_range(0, 99);
    val = (r < 15) ? 16'd0 : (r < 30) ? 16'hffff : 16'($urandom());
    write_reg(REG_STIFFNESS, val);
    r = $urandom_range(0, 99);
    val = (r < 30) ? 16'd0 : (r < 40) ? 16'h7fff : 16'($urandom_range(0, 32767));
    write_reg(REG_DAMPING, val);
    val = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, n_eff - 1))
                                       : 16'($urandom_range(0, 63));
    write_reg(REG_EXCITE_NODE, val);
    val = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, n_eff - 1))
                                       : 16'($urandom_range(0, 63));
    write_reg(REG_PICKUP_NODE, val);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      excite_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (!excite_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        excite_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (sample_queue.size() != 0) begin
        excite_ch.valid <= 1'b1;
        excite_ch.sample_in <= sample_queue.pop_front();
        in_gap <= pick_gap();
      end else begin
        excite_ch.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      pickup_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      pickup_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      pickup_ch.ready <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  // monitor: check results first, then predict from the accepted input
  always @(posedge clk) begin
    in_fire <= !rst && excite_ch.valid && excite_ch.ready;
    if (!rst && pickup_ch.valid && pickup_ch.ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected transaction", pickup_ch.sample_out, '0);
      end else begin
        want = expected_out.pop_front();
        if (pickup_ch.sample_out !== want)
          report_mismatch("mismatch", pickup_ch.sample_out, want);
      end
      results_seen++;
    end
    if (!rst && excite_ch.valid && excite_ch.ready)
      expected_out = {expected_out, verlet_step(excite_ch.sample_in)};
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((excite_ch.valid && excite_ch.ready) || (pickup_ch.valid && pickup_ch.ready)
          || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int count;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    excite_ch.valid = 1'b0;
    excite_ch.sample_in = '0;
    pickup_ch.ready = 1'b0;
    in_fire = 1'b0;
    steady = 1'b0;
    in_gap = 0;
    ready_hold = 0;
    fail_count = 0;
    results_seen = 0;
    last_sample = '0;
    sent = 0;
    clear_string();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: full string, extremes and a full-scale step across them
    push_sample(24'sd0);
    push_sample(24'sh7fffff);
    push_sample(24'sh800000);
    push_sample(24'sh7fffff);
    push_sample(-24'sd1);
    push_sample(24'sd1);
    push_sample(24'sd0);
    drain_all();

    // single mass as a spring to ground, pickup past the end is clamped
    write_reg(REG_MASS_COUNT, 16'd1);
    write_reg(REG_STIFFNESS, 16'hffff);
    write_reg(REG_DAMPING, 16'h7fff);
    write_reg(REG_PICKUP_NODE, 16'd5);
    push_sample(24'sh7fffff);
    push_sample(24'sh800000);
    push_sample(24'sd0);
    push_sample(24'sd0);
    drain_all();

    // zero masses act as one; excite past the end injects nothing
    write_reg(REG_MASS_COUNT, 16'd0);
    write_reg(REG_EXCITE_NODE, 16'd3);
    push_sample(24'sh7fffff);
    push_sample(24'sd100);
    drain_all();

    // count above the maximum saturates; last mass driven and picked up
    write_reg(REG_MASS_COUNT, 16'd127);
    write_reg(REG_STIFFNESS, 16'd0);
    write_reg(REG_DAMPING, 16'd0);
    write_reg(REG_EXCITE_NODE, 16'd63);
    write_reg(REG_PICKUP_NODE, 16'd63);
    push_sample(24'sh800000);
    push_sample(24'sh7fffff);
    push_sample(24'sd0);
    drain_all();

    // stiff two-mass string pushed into saturation
    write_reg(REG_MASS_COUNT, 16'd2);
    write_reg(REG_STIFFNESS, 16'hffff);
    write_reg(REG_EXCITE_NODE, 16'd1);
    write_reg(REG_PICKUP_NODE, 16'd0);
    push_sample(24'sh7fffff);
    push_sample(24'sh800000);
    push_sample(24'sh7fffff);
    push_sample(24'sh800000);
    drain_all();

    // random phases, each under fresh settings
    while (sent < RANDOM_ITEMS) begin
      random_setup();
      steady = ($urandom_range(0, 99) < 20);
      count = $urandom_range(20, 150);
      repeat (count) push_sample(make_sample());
      sent += count;
      drain_all();
    end
    steady = 1'b0;

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- mass_spring_string_verlet_synth_top.f -----
sv/mss_pkg.sv
sv/mss_in_if.sv
sv/mss_out_if.sv
sv/mss_ram.sv
sv/mss_cfg.sv
sv/mss_ctrl.sv
sv/mss_dp.sv
sv/mass_spring_string_verlet_synth_top.sv
test/tb_mass_spring_string_verlet_synth_top.sv
